// ===== hdl/wavelet_packet_filter_bank_unit_macros.svh =====
// assertion macros for the wavelet packet filter bank checker
`ifndef WAVELET_PACKET_FILTER_BANK_UNIT_MACROS_SVH
`define WAVELET_PACKET_FILTER_BANK_UNIT_MACROS_SVH

// same-cycle implication
`define WPFB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wpfb check failed");

// next-cycle implication
`define WPFB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wpfb check failed");

`endif

// ===== hdl/wpfb_pkg.sv =====
package wpfb_pkg;

   localparam int LEVELS     = 5;
   localparam int BAND_COUNT = (1 << LEVELS) - 1;
   localparam int BUF_DEPTH  = 1 << (LEVELS - 1);
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 33;
   localparam int LEVEL_W    = 3;
   localparam int NODE_W     = 5;
   localparam int LVL_W      = 3;
   localparam int N_W        = 4;
   localparam int BAND_W     = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_STORE,
      ST_PAIR_HI
   } ctrl_state_type;

   typedef struct packed {
      logic             load;
      logic             toggle_phase;
      logic             store;
      logic             emit_hi;
      logic             emit_lo;
      logic             swap;
      logic             last;
      logic [LVL_W-1:0] lvl;
      logic [N_W-1:0]   n;
   } cmd_type;

   typedef struct packed {
      logic phase_cur;
      logic phase_next;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/wavelet_packet_filter_bank_unit.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_sample, req_block_start
// rsp     | out       | rsp_valid/rsp_stall  | rsp_level, rsp_node, rsp_coefficient, rsp_last
//
// one item at a time: the item is taken, then levels are entered in turn; a first-of-pair
// level stores its bands and ends the walk, a pair level emits a hi and a lo result per band
// a full item gives 62 results
// reset is synchronous and clears all band histories, phases and the output
// valid; block_start on an item clears the histories and phases before that item is used
// a stalled result holds the walk; req_stall is high while an item is walked
module wavelet_packet_filter_bank_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [wpfb_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_block_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wpfb_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [wpfb_pkg::NODE_W-1:0]          rsp_node,
   output logic signed [wpfb_pkg::COEF_W-1:0]   rsp_coefficient,
   output logic                                 rsp_last
);

   wpfb_pkg::cmd_type    cmd;
   wpfb_pkg::status_type status;

   wpfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wpfb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_node        (rsp_node),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hdl/wpfb_ctrl.sv =====
module wpfb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wpfb_pkg::status_type status,
   output wpfb_pkg::cmd_type    cmd
);

   wpfb_pkg::ctrl_state_type       state_ff, state_in;
   logic                           lo_step_ff, lo_step_in;
   logic [wpfb_pkg::LVL_W-1:0]     lvl_ff, lvl_in;
   logic [wpfb_pkg::N_W-1:0]       n_ff, n_in;
   logic [wpfb_pkg::N_W-1:0]       n_max;
   logic                           n_done;
   logic                           top_lvl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wpfb_pkg::ST_IDLE;
         lo_step_ff <= 1'b0;
         lvl_ff     <= '0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         lo_step_ff <= lo_step_in;
         lvl_ff     <= lvl_in;
         n_ff       <= n_in;
      end
   end

   assign n_max   = (wpfb_pkg::N_W'(1) << lvl_ff) - wpfb_pkg::N_W'(1);
   assign n_done  = (n_ff == n_max);
   assign top_lvl = (lvl_ff == wpfb_pkg::LVL_W'(wpfb_pkg::LEVELS - 1));
   assign req_stall = (state_ff != wpfb_pkg::ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      lo_step_in = lo_step_ff;
      lvl_in     = lvl_ff;
      n_in       = n_ff;
      cmd        = '0;
      cmd.lvl    = lvl_ff;
      cmd.n      = n_ff;
      unique case (state_ff)
         wpfb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               lvl_in   = '0;
               n_in     = '0;
               state_in = wpfb_pkg::ST_LEVEL;
            end
         end
         wpfb_pkg::ST_LEVEL: begin
            cmd.toggle_phase = 1'b1;
            n_in             = '0;
            lo_step_in       = 1'b0;
            state_in = status.phase_cur ? wpfb_pkg::ST_PAIR_HI : wpfb_pkg::ST_STORE;
         end
         wpfb_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            if (n_done) begin
               state_in = wpfb_pkg::ST_IDLE;
            end else begin
               n_in = n_ff + wpfb_pkg::N_W'(1);
            end
         end
         wpfb_pkg::ST_PAIR_HI: begin
            if (status.out_free) begin
               if (!lo_step_ff) begin
                  cmd.emit_hi = 1'b1;
                  lo_step_in  = 1'b1;
               end else begin
                  cmd.emit_lo = 1'b1;
                  cmd.last    = n_done && (top_lvl || !status.phase_next);
                  lo_step_in  = 1'b0;
                  if (!n_done) begin
                     n_in = n_ff + wpfb_pkg::N_W'(1);
                  end else if (top_lvl) begin
                     state_in = wpfb_pkg::ST_IDLE;
                  end else begin
                     cmd.swap = 1'b1;
                     lvl_in   = lvl_ff + wpfb_pkg::LVL_W'(1);
                     state_in = wpfb_pkg::ST_LEVEL;
                  end
               end
            end
         end
         default: begin
            state_in = wpfb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/wpfb_datapath.sv =====
module wpfb_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [wpfb_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   req_block_start,
   input  wpfb_pkg::cmd_type                      cmd,
   output wpfb_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [wpfb_pkg::LEVEL_W-1:0]           rsp_level,
   output logic [wpfb_pkg::NODE_W-1:0]            rsp_node,
   output logic signed [wpfb_pkg::COEF_W-1:0]     rsp_coefficient,
   output logic                                   rsp_last
);

   logic signed [wpfb_pkg::COEF_W-1:0] pair_first_ff [wpfb_pkg::BAND_COUNT];
   logic signed [wpfb_pkg::COEF_W-1:0] two_back_ff   [wpfb_pkg::BAND_COUNT];
   logic signed [wpfb_pkg::COEF_W-1:0] buf_ff [2][wpfb_pkg::BUF_DEPTH];
   logic [wpfb_pkg::LEVELS-1:0]        phase_ff;
   logic                               sel_ff;

   logic                               rsp_valid_ff;
   logic [wpfb_pkg::LEVEL_W-1:0]       level_ff;
   logic [wpfb_pkg::NODE_W-1:0]        node_ff;
   logic signed [wpfb_pkg::COEF_W-1:0] coef_ff;
   logic                               last_ff;

   logic [wpfb_pkg::BAND_W-1:0]        band;
   logic signed [wpfb_pkg::COEF_W-1:0] cur, first, back, hi, lo;
   logic [wpfb_pkg::NODE_W-1:0]        child;
   logic                               clear;
   logic                               emit;
   logic                               top_lvl;
   logic [wpfb_pkg::LVL_W-1:0]         lvl_up;

   assign band = (wpfb_pkg::BAND_W'(1) << cmd.lvl) - wpfb_pkg::BAND_W'(1)
                 + wpfb_pkg::BAND_W'(cmd.n);
   assign cur   = buf_ff[sel_ff][cmd.n];
   assign first = pair_first_ff[band];
   assign back  = two_back_ff[band];
   assign hi    = cur - back;
   assign lo    = back + (first <<< 1) + cur;
   assign child = {cmd.n, cmd.emit_lo};
   assign clear = cmd.load && req_block_start;
   assign emit  = cmd.emit_hi || cmd.emit_lo;
   assign top_lvl = (cmd.lvl == wpfb_pkg::LVL_W'(wpfb_pkg::LEVELS - 1));
   assign lvl_up  = cmd.lvl + wpfb_pkg::LVL_W'(1);

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.phase_cur  = phase_ff[cmd.lvl];
   assign status.phase_next = top_lvl ? 1'b0 : phase_ff[lvl_up];

   // band histories and level phases
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < wpfb_pkg::BAND_COUNT; i++) begin
            pair_first_ff[i] <= '0;
            two_back_ff[i]   <= '0;
         end
         phase_ff <= '0;
      end else begin
         if (cmd.toggle_phase) begin
            phase_ff[cmd.lvl] <= !phase_ff[cmd.lvl];
         end
         if (cmd.store) begin
            pair_first_ff[band] <= cur;
         end
         if (cmd.emit_lo) begin
            two_back_ff[band] <= first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else if (cmd.swap) begin
         sel_ff <= !sel_ff;
      end
   end

   // ping-pong band value buffers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         buf_ff[sel_ff][0] <= wpfb_pkg::COEF_W'(req_sample);
      end
      if (emit && !top_lvl) begin
         buf_ff[!sel_ff][child[wpfb_pkg::N_W-1:0]] <= cmd.emit_lo ? lo : hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         level_ff <= wpfb_pkg::LEVEL_W'(lvl_up);
         node_ff  <= child;
         coef_ff  <= cmd.emit_lo ? lo : hi;
         last_ff  <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = level_ff;
   assign rsp_node        = node_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== hdl/wpfb_checker.sv =====
`include "wavelet_packet_filter_bank_unit_macros.svh"

module wpfb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [wpfb_pkg::LEVEL_W-1:0]         rsp_level,
   input logic [wpfb_pkg::NODE_W-1:0]          rsp_node,
   input logic signed [wpfb_pkg::COEF_W-1:0]   rsp_coefficient,
   input logic                                 rsp_last
);

   `WPFB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_coefficient))
   `WPFB_ASSERT_NOW(a_level_range, rsp_valid, rsp_level != 3'd0 && rsp_level <= 3'd5)
   `WPFB_ASSERT_NOW(a_hi_not_last, rsp_valid && !rsp_node[0], !rsp_last)
   `WPFB_ASSERT_NEXT(a_busy_after_item, req_valid && !req_stall, req_stall)

endmodule

bind wavelet_packet_filter_bank_unit wpfb_checker u_wpfb_checker (.*);

// ===== tb/wavelet_packet_filter_bank_check.sv =====
module wavelet_packet_filter_bank_check
   import wpfb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_block_start,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [LEVEL_W-1:0]         rsp_level,
   input  logic [NODE_W-1:0]          rsp_node,
   input  logic signed [COEF_W-1:0]   rsp_coefficient,
   input  logic                       rsp_last,
   output int                         fail_count,
   output int                         outstanding,
   output int                         items_seen,
   output int                         coefs_checked,
   output int                         full_walks
);

   typedef struct {
      logic [LEVEL_W-1:0]       level;
      logic [NODE_W-1:0]        node;
      logic signed [COEF_W-1:0] coef;
      logic                     is_last;
   } band_coef_type;

   logic signed [COEF_W-1:0] first_of_pair [BAND_COUNT];
   logic signed [COEF_W-1:0] two_back_val [BAND_COUNT];
   logic                     pair_half [LEVELS];
   band_coef_type            pending_coefs [$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      items_seen    = 0;
      coefs_checked = 0;
      full_walks    = 0;
   end

   function automatic void clear_bands();
      foreach (first_of_pair[b]) begin
         first_of_pair[b] = '0;
         two_back_val[b]  = '0;
      end
      foreach (pair_half[l]) begin
         pair_half[l] = 1'b0;
      end
   endfunction

   initial clear_bands();

   // walk the tree level by level, parent order, hi before lo
   function automatic void decompose_sample(input logic signed [SAMPLE_W-1:0] s,
                                            input logic clear);
      logic signed [COEF_W-1:0] cur [32];
      logic signed [COEF_W-1:0] nxt [32];
      logic signed [COEF_W-1:0] hi;
      logic signed [COEF_W-1:0] lo;
      band_coef_type            walk [$];
      band_coef_type            rec;
      int                       width;
      int                       b;

      if (clear) begin
         clear_bands();
      end
      cur[0] = COEF_W'(s);
      width = 1;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         if (!pair_half[lvl]) begin
            for (int n = 0; n < width; n++) begin
               first_of_pair[(1 << lvl) - 1 + n] = cur[n];
            end
            pair_half[lvl] = 1'b1;
            break;
         end
         pair_half[lvl] = 1'b0;
         for (int n = 0; n < width; n++) begin
            b  = (1 << lvl) - 1 + n;
            hi = cur[n] - two_back_val[b];
            lo = two_back_val[b] + (first_of_pair[b] <<< 1) + cur[n];
            two_back_val[b] = first_of_pair[b];
            nxt[2 * n]     = hi;
            nxt[2 * n + 1] = lo;
            rec.level   = LEVEL_W'(lvl + 1);
            rec.node    = NODE_W'(2 * n);
            rec.coef    = hi;
            rec.is_last = 1'b0;
            walk.push_back(rec);
            rec.node = NODE_W'(2 * n + 1);
            rec.coef = lo;
            walk.push_back(rec);
         end
         width = width * 2;
         for (int n = 0; n < width; n++) begin
            cur[n] = nxt[n];
         end
      end
      if (walk.size() > 0) begin
         walk[walk.size() - 1].is_last = 1'b1;
      end
      foreach (walk[i]) begin
         pending_coefs.push_back(walk[i]);
      end
      items_seen++;
      if (walk.size() == (2 << LEVELS) - 2) begin
         full_walks++;
      end
   endfunction

   always @(posedge clock) begin
      band_coef_type want;

      if (reset) begin
         clear_bands();
      end else begin
         if (req_valid && !req_stall) begin
            decompose_sample(req_sample, req_block_start);
         end
         if (rsp_valid && !rsp_stall) begin
            coefs_checked++;
            if (pending_coefs.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected item: level %0d node %0d coef %0d last %0b",
                           rsp_level, rsp_node, rsp_coefficient, rsp_last);
               end
               fail_count++;
            end else begin
               want = pending_coefs.pop_front();
               if (rsp_level !== want.level || rsp_node !== want.node ||
                   rsp_coefficient !== want.coef || rsp_last !== want.is_last) begin
                  if (fail_count < 10) begin
                     $display("mismatch on item %0d: expected level %0d node %0d",
                              coefs_checked, want.level, want.node,
                              " coef %0d last %0b,", want.coef, want.is_last,
                              " got level %0d node %0d", rsp_level, rsp_node,
                              " coef %0d last %0b", rsp_coefficient, rsp_last);
                  end
                  fail_count++;
               end
            end
         end
      end
      outstanding = pending_coefs.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb
   import wpfb_pkg::*;
;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_block_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]         rsp_level;
   logic [NODE_W-1:0]          rsp_node;
   logic signed [COEF_W-1:0]   rsp_coefficient;
   logic                       rsp_last;

   int fail_count;
   int outstanding;
   int items_seen;
   int coefs_checked;
   int full_walks;

   bit hold_request = 1'b0;
   bit quiet_tail   = 1'b0;

   wavelet_packet_filter_bank_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_node        (rsp_node),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last        (rsp_last)
   );

   wavelet_packet_filter_bank_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_node        (rsp_node),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .items_seen      (items_seen),
      .coefs_checked   (coefs_checked),
      .full_walks      (full_walks)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #30000000;
      $display("tb: failure");
      $finish;
   end

   task automatic offer_item(input logic signed [SAMPLE_W-1:0] s, input logic clear);
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_block_start <= clear;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid       <= 1'b0;
      req_sample      <= SAMPLE_W'($urandom);
      req_block_start <= 1'(($urandom));
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // receiver: random stall bursts, one long hold-off, none at the tail
   initial begin
      int stall_left;
      int free_left;

      stall_left = 0;
      free_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall  <= 1'b1;
            stall_left = 400;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (quiet_tail) begin
            rsp_stall <= 1'b0;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 19) - 1;
         end else begin
            rsp_stall <= 1'b0;
            free_left = $urandom_range(1, 60);
         end
      end
   end

   initial begin
      int  sent;
      int  seg_len;
      bit  calm;
      logic clear;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // window start right after reset, alternating full-scale extremes
      for (int i = 0; i < 16; i++) begin
         offer_item((i % 2 == 0) ? 16'sh7fff : 16'sh8000, 1'b0);
      end
      offer_item(16'shffff, 1'b0);
      offer_item(16'sh0000, 1'b0);
      pause_sender(3);
      offer_item(16'sh0001, 1'b0);
      // clear in the middle of a pair
      offer_item(16'sh8000, 1'b1);
      offer_item(16'sh8000, 1'b0);
      offer_item(16'sh8000, 1'b0);
      offer_item(16'sh7fff, 1'b1);
      offer_item(16'sh7fff, 1'b0);

      sent = 0;
      while (sent < 136) begin
         seg_len = $urandom_range(33, 70);
         calm    = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < seg_len && sent < 136; i++) begin
            if (i == 0) begin
               clear = ($urandom_range(0, 3) != 0);
            end else begin
               clear = ($urandom_range(0, 31) == 0);
            end
            offer_item(pick_sample(), clear);
            sent++;
            if (sent == 50) begin
               hold_request = 1'b1;
            end
            if (sent >= 110) begin
               quiet_tail = 1'b1;
            end
            if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
               pause_sender($urandom_range(1, 19));
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);

      $display("run covered %0d samples and %0d coefficients, %0d full five-level walks",
               items_seen, coefs_checked, full_walks);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
